### hw/rtl/md5_pkg.sv
// Shared types, constants and helper functions for the MD5 digest block.
// Used by md5_message_digest; depends on nothing else.
`timescale 1ns / 1ps

package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_DONE
    } md5_state_t;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] wide;
        wide = {x, x} << s;
        return wide[63:32];
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### hw/rtl/md5_message_digest.sv
// MD5 message digest over a byte stream, one compression round per cycle.
// Depends on md5_pkg for the state type, round constants and helpers.
// Bytes are taken one per cycle in the idle state; each full block runs load, 64 rounds, add.
// Closing a message writes the padding bytes at one per cycle, then the length words,
// runs one or two compressions, and registers the digest once the output is free.
// Bytes wait while a block compresses. Reset (aresetn low, synchronous) restores the IV.
`timescale 1ns / 1ps

module md5_message_digest (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_upper,
    output logic [63:0] m_digest_lower
);
    import md5_pkg::*;

    md5_state_t  state_reg, state_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] work_reg [4];
    logic [31:0] work_next [4];
    logic [31:0] block_mem [16];
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  round_reg, round_next;
    logic        last_reg, last_next;
    logic        first_reg, first_next;
    logic        final_reg, final_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] upper_reg, upper_next;
    logic [63:0] lower_reg, lower_next;

    logic        byte_we;
    logic [7:0]  byte_val;
    logic        len_we;

    logic [1:0]  phase;
    logic [31:0] f_val;
    logic [3:0]  g_idx;
    logic [31:0] sum_val;
    logic [31:0] new_b;
    logic [5:0]  pos_inc;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_digest_upper = upper_reg;
    assign m_digest_lower = lower_reg;
    assign pos_inc        = pos_reg + 6'd1;

    always_comb begin
        phase = round_reg[5:4];
        unique case (phase)
            2'd0: begin
                f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                g_idx = round_reg[3:0];
            end
            2'd1: begin
                f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
                g_idx = 4'(round_reg[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                g_idx = 4'(round_reg[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
                g_idx = 4'(round_reg[3:0] * 4'd7);
            end
        endcase
        sum_val = work_reg[0] + f_val + ROUND_K[round_reg] + block_mem[g_idx];
        new_b   = work_reg[1] + rotl32(sum_val, ROT_AMOUNT[{phase, round_reg[1:0]}]);
    end

    always_comb begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        last_next      = last_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        byte_we        = 1'b0;
        byte_val       = s_data_byte;
        len_we         = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next  = s_end_of_message;
                    first_next = 1'b1;
                    if (s_byte_present) begin
                        byte_we  = 1'b1;
                        pos_next = pos_inc;
                        len_next = len_reg + 64'd8;
                        if (pos_inc == 6'd0) begin
                            state_next = ST_LOAD;
                        end else if (s_end_of_message) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                byte_we    = 1'b1;
                byte_val   = first_reg ? PAD_BYTE : 8'd0;
                first_next = 1'b0;
                pos_next   = pos_inc;
                if (pos_inc == 6'd0) begin
                    state_next = ST_LOAD;
                end else if (pos_inc == LEN_POS) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                len_we     = 1'b1;
                final_next = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                work_next  = chain_reg;
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                work_next[0] = work_reg[3];
                work_next[1] = new_b;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 4; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (final_reg) begin
                    state_next = ST_DONE;
                end else if (last_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    upper_next     = {bswap32(chain_reg[0]), bswap32(chain_reg[1])};
                    lower_next     = {bswap32(chain_reg[2]), bswap32(chain_reg[3])};
                    chain_next[0]  = IV0;
                    chain_next[1]  = IV1;
                    chain_next[2]  = IV2;
                    chain_next[3]  = IV3;
                    pos_next       = 6'd0;
                    len_next       = 64'd0;
                    last_next      = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chain_reg[0]  <= IV0;
            chain_reg[1]  <= IV1;
            chain_reg[2]  <= IV2;
            chain_reg[3]  <= IV3;
            work_reg      <= '{default: 32'd0};
            pos_reg       <= 6'd0;
            len_reg       <= 64'd0;
            round_reg     <= 6'd0;
            last_reg      <= 1'b0;
            first_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            last_reg      <= last_next;
            first_reg     <= first_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        upper_reg <= upper_next;
        lower_reg <= lower_next;
    end

    // A byte lands in its lane; the first byte of a word clears the other lanes.
    always_ff @(posedge aclk) begin
        if (byte_we) begin
            unique case (pos_reg[1:0])
                2'd0: block_mem[pos_reg[5:2]] <= {24'd0, byte_val};
                2'd1: block_mem[pos_reg[5:2]][15:8] <= byte_val;
                2'd2: block_mem[pos_reg[5:2]][23:16] <= byte_val;
                default: block_mem[pos_reg[5:2]][31:24] <= byte_val;
            endcase
        end
        if (len_we) begin
            block_mem[14] <= len_reg[31:0];
            block_mem[15] <= len_reg[63:32];
        end
    end

    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ROUND) |-> (round_reg == 6'd0))
        else $error("Round counter is not zero outside the round loop.");

    a_len_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN) |-> (pos_reg == LEN_POS))
        else $error("Length words are written at the wrong block position.");

    a_final_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD && final_reg) |=> (state_reg == ST_DONE))
        else $error("Final compression did not lead to the digest state.");

    a_pad_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD) |-> last_reg)
        else $error("Padding started without an end of message.");

endmodule
